// File: rtl/core/pds_pkg.sv
// Package for the PLL divider search unit: FSM state type, result struct,
// band limits, base words and the reference divider table.
// No dependencies.
package pds_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOUT,
        S_OD,
        S_NR,
        S_NF,
        S_NRNEXT,
        S_DONE
    } pds_state_t;

    typedef struct packed {
        logic [31:0] word;
        logic        found;
    } pds_result_t;

    localparam int unsigned FIN_MHZ = 25;

    // low band limits
    localparam int unsigned LO_REF_MIN = 10;
    localparam int unsigned LO_VCO_MIN = 800;
    localparam int unsigned LO_VCO_MAX = 1600;
    localparam int unsigned LO_OUT_MIN = 100;
    localparam int unsigned LO_OUT_MAX = 1600;
    localparam logic [31:0] LO_BASE    = 32'h0000_0007;

    // high band limits (output minimum 187.5 rounded up)
    localparam int unsigned HI_REF_MIN = 25;
    localparam int unsigned HI_VCO_MIN = 1500;
    localparam int unsigned HI_VCO_MAX = 3000;
    localparam int unsigned HI_OUT_MIN = 188;
    localparam int unsigned HI_OUT_MAX = 3000;
    localparam logic [31:0] HI_BASE    = 32'h8000_0007;

    localparam int unsigned REF_MAX    = 50;

    localparam logic [1:0] OD_LAST = 2'd3;

    // reference frequency 25/NR, truncated, for NR = 0..31 (entry 0 unused)
    localparam logic [4:0] REF_MHZ [32] = '{
        5'd0,  5'd25, 5'd12, 5'd8,  5'd6,  5'd5,  5'd4,  5'd3,
        5'd3,  5'd2,  5'd2,  5'd2,  5'd2,  5'd1,  5'd1,  5'd1,
        5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
        5'd1,  5'd1,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
    };

endpackage

// File: rtl/core/pll_divider_search_unit.sv
// Top level of the PLL divider search: handshakes, band register, result
// register. Depends on pds_pkg and pds_seq.
//
// Usage:
//   cfg_valid/cfg_ready/band_cfg: writes the band select (always ready).
//     1 selects the high band limits and base word, 0 the low band.
//   in_valid/in_ready/target_freq_mhz: one requested output frequency per
//     transfer. in_ready is high only while the sequencer is idle.
//   out_valid/out_ready/pll_word/found: one result per request; pll_word is
//     zero and found low when no setting exists.
// Search order: a request above the search limit goes straight to the
//   result. Otherwise each Fout, post-divider, reference divider and
//   feedback multiplier is tried in turn, then the result is handed over;
//   with the default limits every request in range finds a setting.
// Throughput: one request at a time; the next transfer is taken once the
//   result has moved into the output register.
// Reset clears the band select to the low band and empties the result
//   register. A stalled receiver holds the result in the output register;
//   a further finished search waits in the sequencer until it drains.
module pll_divider_search_unit #(
    parameter int unsigned FOUT_SEARCH_LIMIT = 1300,
    parameter int unsigned REF_DIV_LIMIT     = 32,
    parameter int unsigned FB_MULT_LIMIT     = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        band_cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] target_freq_mhz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pll_word,
    output logic        found
);

    logic                 band_reg;
    logic                 out_valid_reg;
    pds_pkg::pds_result_t out_reg;
    logic                 seq_busy;
    logic                 seq_valid;
    pds_pkg::pds_result_t seq_res;
    logic                 res_ack;
    logic                 start;

    assign cfg_ready = 1'b1;
    assign in_ready  = !seq_busy;
    assign start     = in_valid && in_ready;
    assign res_ack   = seq_valid && (!out_valid_reg || out_ready);

    pds_seq #(
        .FOUT_SEARCH_LIMIT (FOUT_SEARCH_LIMIT),
        .REF_DIV_LIMIT     (REF_DIV_LIMIT),
        .FB_MULT_LIMIT     (FB_MULT_LIMIT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .target    (target_freq_mhz),
        .band_sel  (band_reg),
        .res_ack   (res_ack),
        .busy      (seq_busy),
        .res_valid (seq_valid),
        .res       (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                band_reg <= band_cfg;
            if (res_ack)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
            out_reg <= seq_res;
    end

    assign out_valid = out_valid_reg;
    assign pll_word  = out_reg.word;
    assign found     = out_reg.found;

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (pll_word == 32'd0))
        else $error("miss result with nonzero word");

    a_hit_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (pll_word[2:0] == 3'b111))
        else $error("hit result without base bits");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while search runs");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pll_word) && $stable(found)))
        else $error("stalled result changed");
`endif

endmodule

// File: rtl/core/pds_alu.sv
// Shared add/compare unit of the PLL divider search.
// Depends on nothing; used by pds_seq for every accumulate and window test.
module pds_alu #(
    parameter int unsigned W = 22
) (
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] win_lo,
    input  logic [W-1:0] win_hi,
    output logic [W-1:0] sum,
    output logic         in_win,
    output logic         past_hi
);

    assign sum     = op_a + op_b;
    // op_a tested against the half-open window [win_lo, win_hi)
    assign in_win  = (op_a >= win_lo) && (op_a < win_hi);
    assign past_hi = (op_a >= win_hi);

endmodule

// File: rtl/core/pds_seq.sv
// Search sequencer: walks Fout, post-divider, reference divider and feedback
// multiplier, one step per cycle, through the shared pds_alu.
// Depends on pds_pkg and pds_alu.
module pds_seq #(
    parameter int unsigned FOUT_SEARCH_LIMIT = 1300,
    parameter int unsigned REF_DIV_LIMIT     = 32,
    parameter int unsigned FB_MULT_LIMIT     = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         target,
    input  logic                band_sel,
    input  logic                res_ack,
    output logic                busy,
    output logic                res_valid,
    output pds_pkg::pds_result_t res
);

    localparam int unsigned FOUT_W = $clog2(FOUT_SEARCH_LIMIT + 2);
    localparam int unsigned VCO_W  = FOUT_W + 3;
    localparam int unsigned NR_W   = $clog2(REF_DIV_LIMIT + 1);
    localparam int unsigned NF_W   = $clog2(FB_MULT_LIMIT + 1);
    localparam int unsigned DW     = VCO_W + NR_W + 1;

    pds_pkg::pds_state_t state_reg, state_next;

    logic [FOUT_W-1:0] fout_reg, fout_next;
    logic [1:0]        od_reg,   od_next;
    logic [NR_W-1:0]   nr_reg,   nr_next;
    logic [NF_W-1:0]   nf_reg,   nf_next;
    logic [DW-1:0]     lo_reg,   lo_next;
    logic [DW-1:0]     hi_reg,   hi_next;
    logic [DW-1:0]     acc_reg,  acc_next;
    logic              band_reg, band_next;
    logic [31:0]       word_reg, word_next;
    logic              hit_reg,  hit_next;

    logic [VCO_W-1:0]  vco;
    logic [5:0]        ref_mhz;
    logic              out_ok;
    logic              vco_ok;
    logic              ref_ok;
    logic [DW-1:0]     alu_a;
    logic [DW-1:0]     alu_b;
    logic [DW-1:0]     alu_sum;
    logic              alu_in_win;
    logic              alu_past_hi;
    logic [6:0]        nf_half;
    logic [4:0]        nr_field;
    logic [31:0]       base;

    pds_alu #(
        .W (DW)
    ) u_alu (
        .op_a    (alu_a),
        .op_b    (alu_b),
        .win_lo  (lo_reg),
        .win_hi  (hi_reg),
        .sum     (alu_sum),
        .in_win  (alu_in_win),
        .past_hi (alu_past_hi)
    );

    assign vco     = VCO_W'(fout_reg) << od_reg;
    assign ref_mhz = {1'b0, pds_pkg::REF_MHZ[5'(nr_reg)]};

    always_comb
    begin
        if (band_reg)
        begin
            out_ok = (32'(fout_reg) >= pds_pkg::HI_OUT_MIN)
                  && (32'(fout_reg) <= pds_pkg::HI_OUT_MAX);
            vco_ok = (32'(vco) >= pds_pkg::HI_VCO_MIN)
                  && (32'(vco) <= pds_pkg::HI_VCO_MAX);
            ref_ok = (32'(ref_mhz) >= pds_pkg::HI_REF_MIN)
                  && (32'(ref_mhz) <= pds_pkg::REF_MAX);
            base   = pds_pkg::HI_BASE;
        end
        else
        begin
            out_ok = (32'(fout_reg) >= pds_pkg::LO_OUT_MIN)
                  && (32'(fout_reg) <= pds_pkg::LO_OUT_MAX);
            vco_ok = (32'(vco) >= pds_pkg::LO_VCO_MIN)
                  && (32'(vco) <= pds_pkg::LO_VCO_MAX);
            ref_ok = (32'(ref_mhz) >= pds_pkg::LO_REF_MIN)
                  && (32'(ref_mhz) <= pds_pkg::REF_MAX);
            base   = pds_pkg::LO_BASE;
        end
    end

    assign nf_half  = 7'(nf_reg >> 1) - 7'd1;
    assign nr_field = 5'(nr_reg - 1'b1);

    // one adder, operands picked by the step in progress
    always_comb
    begin
        unique case (state_reg)
            pds_pkg::S_NR:
            begin
                alu_a = lo_reg;
                alu_b = DW'(nr_reg) << od_reg;
            end
            pds_pkg::S_NF:
            begin
                alu_a = acc_reg;
                alu_b = DW'(pds_pkg::FIN_MHZ);
            end
            pds_pkg::S_NRNEXT:
            begin
                alu_a = lo_reg;
                alu_b = DW'(vco);
            end
            default:
            begin
                alu_a = acc_reg;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        fout_next  = fout_reg;
        od_next    = od_reg;
        nr_next    = nr_reg;
        nf_next    = nf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        acc_next   = acc_reg;
        band_next  = band_reg;
        word_next  = word_reg;
        hit_next   = hit_reg;

        unique case (state_reg)
            pds_pkg::S_IDLE:
            begin
                if (start)
                begin
                    band_next = band_sel;
                    word_next = '0;
                    hit_next  = 1'b0;
                    if (32'(target) > FOUT_SEARCH_LIMIT)
                        state_next = pds_pkg::S_DONE;
                    else
                    begin
                        fout_next  = FOUT_W'(target);
                        state_next = pds_pkg::S_FOUT;
                    end
                end
            end
            pds_pkg::S_FOUT:
            begin
                if (32'(fout_reg) > FOUT_SEARCH_LIMIT)
                    state_next = pds_pkg::S_DONE;
                else if (out_ok)
                begin
                    od_next    = 2'd0;
                    state_next = pds_pkg::S_OD;
                end
                else
                    fout_next = FOUT_W'(fout_reg + 1'b1);
            end
            pds_pkg::S_OD:
            begin
                if (vco_ok)
                begin
                    lo_next    = DW'(vco);
                    nr_next    = NR_W'(1);
                    state_next = pds_pkg::S_NR;
                end
                else if (od_reg == pds_pkg::OD_LAST)
                begin
                    fout_next  = FOUT_W'(fout_reg + 1'b1);
                    state_next = pds_pkg::S_FOUT;
                end
                else
                    od_next = od_reg + 2'd1;
            end
            pds_pkg::S_NR:
            begin
                if (32'(nr_reg) == REF_DIV_LIMIT)
                begin
                    // dividers exhausted: next post-divider or next Fout
                    if (od_reg == pds_pkg::OD_LAST)
                    begin
                        fout_next  = FOUT_W'(fout_reg + 1'b1);
                        state_next = pds_pkg::S_FOUT;
                    end
                    else
                    begin
                        od_next    = od_reg + 2'd1;
                        state_next = pds_pkg::S_OD;
                    end
                end
                else if (ref_ok)
                begin
                    hi_next    = alu_sum;
                    acc_next   = DW'(pds_pkg::FIN_MHZ);
                    nf_next    = NF_W'(1);
                    state_next = pds_pkg::S_NF;
                end
                else
                    state_next = pds_pkg::S_NRNEXT;
            end
            pds_pkg::S_NF:
            begin
                // lo = Fout*NR*NO, hi = lo + NR*NO; match when 25*NF in [lo, hi)
                if (32'(nf_reg) == FB_MULT_LIMIT)
                    state_next = pds_pkg::S_NRNEXT;
                else if (alu_in_win)
                begin
                    hit_next   = 1'b1;
                    word_next  = base | (32'(nr_field) << 16) | (32'(nf_half) << 21)
                               | (32'(od_reg) << 28);
                    state_next = pds_pkg::S_DONE;
                end
                else if (alu_past_hi)
                    state_next = pds_pkg::S_NRNEXT;
                else
                begin
                    acc_next = alu_sum;
                    nf_next  = NF_W'(nf_reg + 1'b1);
                end
            end
            pds_pkg::S_NRNEXT:
            begin
                lo_next    = alu_sum;
                nr_next    = NR_W'(nr_reg + 1'b1);
                state_next = pds_pkg::S_NR;
            end
            pds_pkg::S_DONE:
            begin
                if (res_ack)
                    state_next = pds_pkg::S_IDLE;
            end
            default:
                state_next = pds_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pds_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        fout_reg <= fout_next;
        od_reg   <= od_next;
        nr_reg   <= nr_next;
        nf_reg   <= nf_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        acc_reg  <= acc_next;
        band_reg <= band_next;
        word_reg <= word_next;
        hit_reg  <= hit_next;
    end

    assign busy      = (state_reg != pds_pkg::S_IDLE);
    assign res_valid = (state_reg == pds_pkg::S_DONE);
    assign res.word  = word_reg;
    assign res.found = hit_reg;

endmodule
